// ===== hw/rtl/zpdpc_pkg.sv =====
// Shared types and constants for the zoned PD position controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package zpdpc_pkg;

    localparam int POS_W   = 15;
    localparam int GAIN_W  = 10;
    localparam int CAPS_W  = 32;
    localparam int VEL_W   = 8;
    localparam int ERR_W   = POS_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int PRODP_W = GAIN_W + 1 + ERR_W;
    localparam int PRODD_W = GAIN_W + 1 + DIFF_W;
    localparam int SUM_W   = PRODD_W + 1;
    localparam int Q_BITS  = 8;
    localparam int PD_W    = SUM_W - Q_BITS;
    localparam int LIMIT_W = 7;
    localparam int CAP_W   = 8;
    localparam int INDEX_W = 3;

    typedef enum logic [INDEX_W-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_D         = 3'd1,
        REG_FINAL_POSITION = 3'd2,
        REG_ZONE_ONE       = 3'd3,
        REG_ZONE_TWO       = 3'd4,
        REG_ZONE_THREE     = 3'd5,
        REG_PROFILE_CAPS   = 3'd6
    } reg_index_t;

    localparam logic [1:0] OP_NONE        = 2'd0;
    localparam logic [1:0] OP_PLACE_PROG  = 2'd1;
    localparam logic [1:0] OP_PLACE_FIXED = 2'd2;
    localparam logic [1:0] OP_CANCEL      = 2'd3;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_PROG  = 2'd1;
    localparam logic [1:0] MODE_FIXED = 2'd2;

    localparam logic [CAP_W-1:0] CAP_FIXED_ONE   = 8'd40;
    localparam logic [CAP_W-1:0] CAP_FIXED_TWO   = 8'd30;
    localparam logic [CAP_W-1:0] CAP_FIXED_THREE = 8'd15;
    localparam logic [CAP_W-1:0] CAP_DEFAULT     = 8'd100;
    localparam logic [LIMIT_W-1:0] VEL_MAX       = 7'd127;

    localparam logic signed [POS_W-1:0] HOME_HI    = 15'sd10;
    localparam logic signed [POS_W-1:0] HOME_LO    = -15'sd10;
    localparam logic signed [ERR_W-1:0] END_MARGIN = 16'sd5;

    localparam logic [GAIN_W-1:0] GAIN_P_RESET = 10'd218;
    localparam logic [GAIN_W-1:0] GAIN_D_RESET = 10'd77;

    typedef struct packed {
        logic [GAIN_W-1:0]        gain_p;
        logic [GAIN_W-1:0]        gain_d;
        logic signed [POS_W-1:0]  final_position;
        logic signed [POS_W-1:0]  zone_one;
        logic signed [POS_W-1:0]  zone_two;
        logic signed [POS_W-1:0]  zone_three;
        logic [CAPS_W-1:0]        profile_caps;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
        logic [LIMIT_W-1:0]       limit;
        logic                     override;
        logic signed [VEL_W-1:0]  manual;
        logic                     zero;
        logic                     home;
    } work_t;

endpackage

`default_nettype wire

// ===== hw/rtl/zpdpc_cfg.sv =====
// Configuration register file of the zoned PD position controller.
// Depends on zpdpc_pkg.
`default_nettype none

module zpdpc_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          write_enable,
    input  wire logic [zpdpc_pkg::INDEX_W-1:0] write_index,
    input  wire logic [zpdpc_pkg::CAPS_W-1:0]  write_data,
    output zpdpc_pkg::cfg_t                    cfg
);
    import zpdpc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p         <= GAIN_P_RESET;
            cfg_reg.gain_d         <= GAIN_D_RESET;
            cfg_reg.final_position <= '0;
            cfg_reg.zone_one       <= '0;
            cfg_reg.zone_two       <= '0;
            cfg_reg.zone_three     <= '0;
            cfg_reg.profile_caps   <= '0;
        end
        else if (write_enable)
        begin
            unique case (reg_index_t'(write_index))
                REG_GAIN_P:         cfg_reg.gain_p         <= write_data[GAIN_W-1:0];
                REG_GAIN_D:         cfg_reg.gain_d         <= write_data[GAIN_W-1:0];
                REG_FINAL_POSITION: cfg_reg.final_position <= write_data[POS_W-1:0];
                REG_ZONE_ONE:       cfg_reg.zone_one       <= write_data[POS_W-1:0];
                REG_ZONE_TWO:       cfg_reg.zone_two       <= write_data[POS_W-1:0];
                REG_ZONE_THREE:     cfg_reg.zone_three     <= write_data[POS_W-1:0];
                REG_PROFILE_CAPS:   cfg_reg.profile_caps   <= write_data;
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/zpdpc_ctrl.sv =====
// Control stage: placement mode, target, latch and last error, speed cap pick.
// Depends on zpdpc_pkg.
`default_nettype none

module zpdpc_ctrl (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               step,
    input  zpdpc_pkg::cfg_t                         cfg,
    input  wire logic signed [zpdpc_pkg::POS_W-1:0] position,
    input  wire logic [1:0]                         operation,
    input  wire logic                               limit_pressed,
    input  wire logic                               manual_active,
    input  wire logic signed [zpdpc_pkg::VEL_W-1:0] manual_velocity,
    output zpdpc_pkg::work_t                        work
);
    import zpdpc_pkg::*;

    logic signed [POS_W-1:0] target_reg, target_next;
    logic signed [ERR_W-1:0] last_error_reg;
    logic [1:0]              mode_reg, mode_next;
    logic                    latch_reg, latch_next;

    logic signed [POS_W-1:0]  target_a, target_b, pos_eff;
    logic [1:0]               mode_a;
    logic                     latch_a;
    logic                     op_home;
    logic [CAP_W-1:0]         cap;
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic                     zeroing;
    logic                     override;
    logic                     place_end;
    logic signed [VEL_W-1:0]  manual_sat;

    always_comb
    begin
        target_a = target_reg;
        mode_a   = mode_reg;
        latch_a  = latch_reg;
        op_home  = 1'b0;
        unique case (operation)
            OP_PLACE_PROG:
            begin
                mode_a   = MODE_PROG;
                target_a = cfg.final_position;
                latch_a  = 1'b1;
            end
            OP_CANCEL:
            begin
                mode_a  = MODE_IDLE;
                op_home = 1'b1;
                latch_a = 1'b1;
            end
            OP_PLACE_FIXED:
            begin
                mode_a   = MODE_FIXED;
                target_a = cfg.final_position;
            end
            OP_NONE:
            begin
                if (!latch_reg)
                begin
                    mode_a   = MODE_IDLE;
                    target_a = position;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        cap = CAP_DEFAULT;
        if (mode_a == MODE_FIXED)
        begin
            if (position >= cfg.zone_one)
                cap = CAP_FIXED_ONE;
            else if (position > cfg.zone_two)
                cap = CAP_FIXED_TWO;
            else if (position < cfg.zone_two && position >= cfg.final_position)
                cap = CAP_FIXED_THREE;
        end
        else if (mode_a == MODE_PROG)
        begin
            if (position >= cfg.zone_one)
                cap = cfg.profile_caps[7:0];
            else if (position > cfg.zone_two)
                cap = cfg.profile_caps[15:8];
            else if (position < cfg.zone_two && position >= cfg.zone_three)
                cap = cfg.profile_caps[23:16];
            else if (position < cfg.zone_three && position >= cfg.final_position)
                cap = cfg.profile_caps[31:24];
        end
    end

    assign err  = ERR_W'(target_a) - ERR_W'(position);
    assign diff = DIFF_W'(err) - DIFF_W'(last_error_reg);

    assign zeroing    = limit_pressed && (mode_a != MODE_PROG);
    assign pos_eff    = zeroing ? '0 : position;
    assign override   = limit_pressed ? (manual_active && manual_velocity[VEL_W-1])
                                      : manual_active;
    assign manual_sat = (manual_velocity == {1'b1, {(VEL_W-1){1'b0}}})
                      ? {1'b1, {(VEL_W-2){1'b0}}, 1'b1} : manual_velocity;
    assign place_end  = (ERR_W'(pos_eff) + END_MARGIN) <= ERR_W'(cfg.final_position);

    always_comb
    begin
        target_b = zeroing ? '0 : target_a;
        if (override)
            target_b = pos_eff;
        if (place_end)
        begin
            mode_next   = MODE_IDLE;
            target_next = pos_eff;
            latch_next  = 1'b0;
        end
        else
        begin
            mode_next   = mode_a;
            target_next = target_b;
            latch_next  = (pos_eff == '0) ? 1'b0 : latch_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= '0;
            last_error_reg <= '0;
            mode_reg       <= MODE_IDLE;
            latch_reg      <= 1'b0;
        end
        else if (step)
        begin
            target_reg     <= target_next;
            last_error_reg <= err;
            mode_reg       <= mode_next;
            latch_reg      <= latch_next;
        end
    end

    assign work.err      = err;
    assign work.diff     = diff;
    assign work.limit    = (cap > CAP_W'(VEL_MAX)) ? VEL_MAX : cap[LIMIT_W-1:0];
    assign work.override = override;
    assign work.manual   = manual_sat;
    assign work.zero     = zeroing;
    assign work.home     = op_home || (!limit_pressed && !manual_active
                           && position < HOME_HI && position > HOME_LO
                           && target_a == '0);

    ctrl_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != 2'b11)
        else $error("placement mode register holds an unused code");

endmodule

`default_nettype wire

// ===== hw/rtl/zpdpc_pd.sv =====
// PD arithmetic: registered gain products, then Q8 floor, clamp and output select.
// Depends on zpdpc_pkg.
`default_nettype none

module zpdpc_pd (
    input  wire logic                                clk,
    input  wire logic                                load,
    input  wire logic [zpdpc_pkg::GAIN_W-1:0]        gain_p,
    input  wire logic [zpdpc_pkg::GAIN_W-1:0]        gain_d,
    input  zpdpc_pkg::work_t                         work,
    output logic signed [zpdpc_pkg::VEL_W-1:0]       velocity,
    output logic                                     zero,
    output logic                                     home
);
    import zpdpc_pkg::*;

    logic signed [PRODP_W-1:0] prod_p_reg;
    logic signed [PRODD_W-1:0] prod_d_reg;
    work_t                     work_reg;

    logic signed [SUM_W-1:0] sum;
    logic signed [PD_W-1:0]  pd;
    logic signed [PD_W-1:0]  bound;
    logic signed [PD_W-1:0]  clamped;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_p_reg <= PRODP_W'($signed({1'b0, gain_p}) * work.err);
            prod_d_reg <= PRODD_W'($signed({1'b0, gain_d}) * work.diff);
            work_reg   <= work;
        end
    end

    assign sum   = SUM_W'(prod_p_reg) + SUM_W'(prod_d_reg);
    assign pd    = PD_W'(sum >>> Q_BITS);
    assign bound = $signed({{(PD_W-LIMIT_W){1'b0}}, work_reg.limit});

    always_comb
    begin
        if (pd > bound)
            clamped = bound;
        else if (pd < -bound)
            clamped = -bound;
        else
            clamped = pd;
    end

    assign velocity = work_reg.override ? work_reg.manual : clamped[VEL_W-1:0];
    assign zero     = work_reg.zero;
    assign home     = work_reg.home;

endmodule

`default_nettype wire

// ===== hw/rtl/zoned_pd_position_controller_unit.sv =====
// Zoned PD position controller, top level: input register, control stage,
// PD stage and output register. Depends on zpdpc_pkg, zpdpc_cfg, zpdpc_ctrl, zpdpc_pd.
//
// One result transaction per input transaction. A new transaction is taken every
// cycle while in_stall is low. Each result passes the input register, control
// register, product register and output register in order. The control stage updates
// target, last error and placement state in the cycle an item leaves the input
// register, so consecutive ticks chain at full rate. Each stage holds its item
// only while the stage after it is full and blocked, so bubbles close up and an
// input is taken while a finished result still waits at the output. Configuration
// writes take effect on the next cycle and must be made with the pipeline empty.
`default_nettype none

module zoned_pd_position_controller_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               write_enable,
    input  wire logic [zpdpc_pkg::INDEX_W-1:0]      write_index,
    input  wire logic [zpdpc_pkg::CAPS_W-1:0]       write_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [zpdpc_pkg::POS_W-1:0] position,
    input  wire logic [1:0]                         operation,
    input  wire logic                               limit_pressed,
    input  wire logic                               manual_active,
    input  wire logic signed [zpdpc_pkg::VEL_W-1:0] manual_velocity,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [zpdpc_pkg::VEL_W-1:0]      motor_velocity,
    output logic                                    zero_position,
    output logic                                    home_request
);
    import zpdpc_pkg::*;

    cfg_t  cfg;
    work_t work;
    work_t work_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    logic signed [POS_W-1:0] position_reg;
    logic [1:0]              operation_reg;
    logic                    limit_reg;
    logic                    manual_reg;
    logic signed [VEL_W-1:0] manual_velocity_reg;

    logic signed [VEL_W-1:0] velocity;
    logic                    zero;
    logic                    home;

    logic signed [VEL_W-1:0] motor_velocity_reg;
    logic                    zero_position_reg;
    logic                    home_request_reg;

    assign en4 = !v4_reg || !out_stall;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;

    zpdpc_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .cfg          (cfg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            position_reg        <= position;
            operation_reg       <= operation;
            limit_reg           <= limit_pressed;
            manual_reg          <= manual_active;
            manual_velocity_reg <= manual_velocity;
        end
        if (en2)
            work_reg <= work;
        if (en4)
        begin
            motor_velocity_reg <= velocity;
            zero_position_reg  <= zero;
            home_request_reg   <= home;
        end
    end

    zpdpc_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (en2 && v1_reg),
        .cfg             (cfg),
        .position        (position_reg),
        .operation       (operation_reg),
        .limit_pressed   (limit_reg),
        .manual_active   (manual_reg),
        .manual_velocity (manual_velocity_reg),
        .work            (work)
    );

    zpdpc_pd u_pd (
        .clk      (clk),
        .load     (en3),
        .gain_p   (cfg.gain_p),
        .gain_d   (cfg.gain_d),
        .work     (work_reg),
        .velocity (velocity),
        .zero     (zero),
        .home     (home)
    );

    assign out_valid      = v4_reg;
    assign motor_velocity = motor_velocity_reg;
    assign zero_position  = zero_position_reg;
    assign home_request   = home_request_reg;

    top_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled while the pipeline has a free stage");

    top_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (motor_velocity != {1'b1, {(VEL_W-1){1'b0}}}))
        else $error("velocity result outside the symmetric range");

    top_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !v3_reg) |=> !out_valid)
        else $error("result repeated after it was taken");

endmodule

`default_nettype wire
